// ===== sv/fpe_pkg.sv =====
// fpe_pkg: shared types, widths, register codes and sine table function
// for the flight path extrapolator. No dependencies.
package fpe_pkg;

  localparam int DEF_MAX_STEPS = 64;
  localparam int DEF_SINE_BITS = 10;

  // configuration port
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 15;
  localparam int STEP_CNT_W  = 7;
  localparam int STEP_NUM_W  = 6;

  localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_BAND = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL_BAND = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLIMB_ONE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_CLIMB_TWO  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_COUNT = 3'd4;

  // datapath widths
  localparam int SIN_W   = 17;  // table magnitude, up to 65536
  localparam int DIST_W  = 25;  // ground speed * 1852
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int QUOT_W  = 18;
  localparam int ACC_W   = 34;  // position and altitude accumulators
  localparam int VS_W    = 18;  // running vertical speed

  localparam logic [13:0] GS_MAX       = 14'd16383;
  localparam int          KT_TO_M      = 1852;
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // divide by 225 * 2^16 with rounding: add half, drop 16 bits,
  // then multiply by ceil(2^33 / 225) and drop 33 bits (exact below 2^25)
  localparam longint HALF_DIV    = 64'd7372800;
  localparam int     ROUND_SHIFT = 16;
  localparam longint RECIP       = 64'd38177488;
  localparam int     RECIP_SHIFT = 33;

  localparam longint Q30 = 64'sd1073741824;

  typedef struct packed {
    logic              start_valid;
    logic signed [31:0] start_east;
    logic signed [31:0] start_north;
    logic signed [31:0] start_altitude;
    logic [15:0]        track_angle;
    logic signed [15:0] track_rate;
    logic [13:0]        ground_speed;
    logic signed [11:0] ground_speed_rate;
    logic signed [15:0] vertical_speed;
    logic signed [15:0] vertical_accel;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]    point_east;
    logic signed [31:0]    point_north;
    logic signed [31:0]    point_altitude;
    logic [STEP_NUM_W-1:0] step_number;
    logic                  last_point;
  } out_item_t;

  typedef struct packed {
    logic             neg;
    logic [SIN_W-1:0] mag;
  } sine_t;

  function automatic longint qmul(input longint a, input longint b);
    return (a * b) / Q30;
  endfunction

  // quarter-wave sine entry k in Q16, odd degree-9 polynomial in Q30
  function automatic longint poly_sine_q16(input int k, input int qbits);
    longint x;
    longint x2;
    longint p;
    longint s;
    x  = longint'(k) * (Q30 >>> qbits);
    x2 = qmul(x, x);
    p  = 64'sd172272;
    p  = -64'sd5026995 + qmul(p, x2);
    p  = 64'sd85569306 + qmul(p, x2);
    p  = -64'sd693598669 + qmul(p, x2);
    p  = 64'sd1686629713 + qmul(p, x2);
    s  = qmul(p, x);
    if (s < 0) s = 0;
    s = (s + 8192) / 16384;
    if (s > 65536) s = 65536;
    return s;
  endfunction

endpackage

// ===== sv/flight_path_extrapolator.sv =====
// flight_path_extrapolator: top level, config registers, sequencer, state
// Depends on fpe_pkg, fpe_sine, fpe_mul.
//
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+---------------------------
//  config    | cfg_we_i, cfg_addr_i, cfg_wdata_i        | write when cfg_we_i high
//  input     | start, busy, item_i                      | beat when start && !busy
//  result    | point_valid_o, point_o                   | one-cycle strobe, no stall
//
// Each point steps through STEP, MUL_E, RND, DIV_E, ACC_E and ACC_N, using
// the shared multiplier four times per point (two sine products, two divides
// by reciprocal). busy is high for the whole run; an invalid start or a zero
// step count leaves busy low. Reset restores register defaults and goes
// idle. The receiver cannot stall; each point is shown for one cycle.
module flight_path_extrapolator import fpe_pkg::*; #(
  parameter int MAX_STEPS       = DEF_MAX_STEPS,
  parameter int SINE_TABLE_BITS = DEF_SINE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              item_i,
  output logic                  point_valid_o,
  output out_item_t             point_o
);

  localparam int NW = $clog2(MAX_STEPS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STEP  = 3'd1;
  localparam logic [2:0] ST_MUL_E = 3'd2;
  localparam logic [2:0] ST_RND   = 3'd3;
  localparam logic [2:0] ST_DIV_E = 3'd4;
  localparam logic [2:0] ST_ACC_E = 3'd5;
  localparam logic [2:0] ST_ACC_N = 3'd6;

  // configuration
  logic [CFG_DATA_W-1:0] level_band_q, accel_band_q, climb_one_q, climb_two_q;
  logic [STEP_CNT_W-1:0] step_count_q;

  // control
  logic [2:0]    state_q;
  logic [NW-1:0] idx_q, n_q, n_sat;
  logic          valid_q;
  logic          is_last;

  // flight state
  logic signed [ACC_W-1:0] east_q, north_q, alt_q;
  logic [15:0]             trk_q, dtrk_q;
  logic [13:0]             gs_q;
  logic signed [11:0]      dgs_q;
  logic signed [VS_W-1:0]  vs_q;
  logic signed [15:0]      va_q, targ_q;
  logic [DIST_W-1:0]       dist_q, t_q;
  sine_t                   sin_e_q, sin_n_q;
  out_item_t               point_q;

  // combinational
  logic signed [15:0]      targ_d;
  logic signed [VS_W-1:0]  vs_next;
  logic [15:0]             trk_next;
  logic [13:0]             gs_next;
  logic signed [ACC_W-1:0] alt_next, north_next, delta;
  logic [DIST_W-1:0]       dist_next, t_d;
  sine_t                   sin_e_d, sin_n_d;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       rnd_sum;
  logic [QUOT_W-1:0]       quot;

  function automatic logic [VS_W+1:0] mag_of(input logic signed [VS_W+1:0] v);
    return v[VS_W+1] ? (VS_W+2)'(-v) : (VS_W+2)'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) return v[31:0];
    return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_band_q <= 15'd260;
      accel_band_q <= 15'd65;
      climb_one_q  <= 15'd2601;
      climb_two_q  <= 15'd5852;
      step_count_q <= 7'd60;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_LEVEL_BAND: level_band_q <= cfg_wdata_i;
        CFG_ACCEL_BAND: accel_band_q <= cfg_wdata_i;
        CFG_CLIMB_ONE:  climb_one_q  <= cfg_wdata_i;
        CFG_CLIMB_TWO:  climb_two_q  <= cfg_wdata_i;
        CFG_STEP_COUNT: step_count_q <= cfg_wdata_i[STEP_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_sat = (step_count_q > STEP_CNT_W'(MAX_STEPS)) ? NW'(MAX_STEPS)
                                                         : NW'(step_count_q);

  // target vertical speed from the start item
  always_comb begin
    logic signed [16:0] v, a, lb, ab, c1, c2, mag;
    logic               pos, level, brake, boost;
    v     = 17'(item_i.vertical_speed);
    a     = 17'(item_i.vertical_accel);
    lb    = {2'b00, level_band_q};
    ab    = {2'b00, accel_band_q};
    c1    = {2'b00, climb_one_q};
    c2    = {2'b00, climb_two_q};
    mag   = v[16] ? -v : v;
    pos   = (v > 17'sd0);
    level = (v > -lb) && (v < lb);
    brake = (!pos && a > ab) || (pos && a < -ab);
    boost = (!pos && a < -ab) || (pos && a > ab);
    if (level || brake) begin
      targ_d = '0;
    end else if (boost && mag < c1) begin
      targ_d = pos ? 16'(c1) : 16'(-c1);
    end else if (boost && mag < c2) begin
      targ_d = pos ? 16'(c2) : 16'(-c2);
    end else begin
      targ_d = item_i.vertical_speed;
    end
  end

  // one second of flight state update
  always_comb begin
    logic signed [VS_W:0]   vs_move;
    logic signed [VS_W+1:0] d_keep, d_move;
    logic signed [15:0]     gs_sum;
    vs_move = (VS_W+1)'(vs_q) + (VS_W+1)'(va_q);
    d_keep  = (VS_W+2)'(vs_q) - (VS_W+2)'(targ_q);
    d_move  = (VS_W+2)'(vs_move) - (VS_W+2)'(targ_q);
    // step by the acceleration only while it closes on the target
    vs_next = (mag_of(d_keep) > mag_of(d_move)) ? VS_W'(vs_move) : VS_W'(targ_q);
    trk_next = trk_q + dtrk_q;
    gs_sum   = $signed({2'b00, gs_q}) + 16'(dgs_q);
    if (gs_sum < 16'sd0) begin
      gs_next = '0;
    end else if (gs_sum > $signed({2'b00, GS_MAX})) begin
      gs_next = GS_MAX;
    end else begin
      gs_next = gs_sum[13:0];
    end
    alt_next  = alt_q + ACC_W'(vs_next);
    dist_next = DIST_W'(gs_next) * DIST_W'(KT_TO_M);
  end

  fpe_sine #(.TABLE_BITS(SINE_TABLE_BITS)) u_sine_e (
    .angle_i (trk_next),
    .sine_o  (sin_e_d)
  );

  fpe_sine #(.TABLE_BITS(SINE_TABLE_BITS)) u_sine_n (
    .angle_i (trk_next + QUARTER_TURN),
    .sine_o  (sin_n_d)
  );

  // shared multiplier operand select
  always_comb begin
    if (state_q inside {ST_DIV_E, ST_ACC_E}) begin
      mul_a = t_q;
      mul_b = MUL_B_W'(RECIP);
    end else if (state_q == ST_RND) begin
      mul_a = dist_q;
      mul_b = MUL_B_W'(sin_n_q.mag);
    end else begin
      mul_a = dist_q;
      mul_b = MUL_B_W'(sin_e_q.mag);
    end
  end

  fpe_mul u_mul (
    .clk_i (clk_i),
    .en_i  (busy),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    logic [ACC_W-1:0] quot_ext;
    logic             neg;
    rnd_sum    = prod + PROD_W'(HALF_DIV);
    t_d        = rnd_sum[ROUND_SHIFT +: DIST_W];
    quot       = prod[RECIP_SHIFT +: QUOT_W];
    quot_ext   = {{(ACC_W-QUOT_W){1'b0}}, quot};
    neg        = (state_q == ST_ACC_N) ? sin_n_q.neg : sin_e_q.neg;
    delta      = neg ? -quot_ext : quot_ext;
    north_next = north_q + delta;
  end

  assign is_last = (idx_q == NW'(n_q - 1'b1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      n_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            idx_q <= '0;
            n_q   <= n_sat;
            if (item_i.start_valid && n_sat != '0) state_q <= ST_STEP;
          end
        end
        ST_STEP:  state_q <= ST_MUL_E;
        ST_MUL_E: state_q <= ST_RND;
        ST_RND:   state_q <= ST_DIV_E;
        ST_DIV_E: state_q <= ST_ACC_E;
        ST_ACC_E: state_q <= ST_ACC_N;
        ST_ACC_N: begin
          valid_q <= 1'b1;
          idx_q   <= idx_q + 1'b1;
          state_q <= is_last ? ST_IDLE : ST_STEP;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          east_q  <= ACC_W'(item_i.start_east);
          north_q <= ACC_W'(item_i.start_north);
          alt_q   <= ACC_W'(item_i.start_altitude);
          trk_q   <= item_i.track_angle;
          dtrk_q  <= item_i.track_rate;
          gs_q    <= item_i.ground_speed;
          dgs_q   <= item_i.ground_speed_rate;
          vs_q    <= VS_W'(item_i.vertical_speed);
          va_q    <= item_i.vertical_accel;
          targ_q  <= targ_d;
        end
      end
      ST_STEP: begin
        vs_q    <= vs_next;
        trk_q   <= trk_next;
        gs_q    <= gs_next;
        alt_q   <= alt_next;
        dist_q  <= dist_next;
        sin_e_q <= sin_e_d;
        sin_n_q <= sin_n_d;
      end
      ST_RND:   t_q <= t_d;
      ST_DIV_E: t_q <= t_d;
      ST_ACC_E: east_q <= east_q + delta;
      ST_ACC_N: begin
        north_q                <= north_next;
        point_q.point_east     <= sat32(east_q);
        point_q.point_north    <= sat32(north_next);
        point_q.point_altitude <= sat32(alt_q);
        point_q.step_number    <= STEP_NUM_W'(idx_q);
        point_q.last_point     <= is_last;
      end
      default: ;
    endcase
  end

  assign busy          = (state_q != ST_IDLE);
  assign point_valid_o = valid_q;
  assign point_o       = point_q;

`ifndef NO_ASSERTIONS
  a_point_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o |-> $past(busy))
    else $error("point beat without a run in progress");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o && point_o.last_point |-> !busy)
    else $error("run still busy after its last point");

  a_point_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_valid_o && !point_o.last_point |-> ##6 point_valid_o)
    else $error("next point not six cycles after the previous one");

  a_invalid_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !item_i.start_valid |=> !busy)
    else $error("invalid start item began a run");
`endif

endmodule

// ===== sv/fpe_sine.sv =====
// fpe_sine: track angle to Q16 sine, quarter-wave constant table
// Depends on fpe_pkg.
module fpe_sine import fpe_pkg::*; #(
  parameter int TABLE_BITS = DEF_SINE_BITS
) (
  input  logic [15:0] angle_i,
  output sine_t       sine_o
);

  localparam int QB          = TABLE_BITS - 2;
  localparam int QLEN        = 1 << QB;
  localparam int ANGLE_SHIFT = 16 - TABLE_BITS;

  logic [SIN_W-1:0]      tbl [QLEN+1];
  logic [16:0]           rnd_sum;
  logic [TABLE_BITS-1:0] idx;
  logic [1:0]            quad;
  logic [QB:0]           tidx;

  for (genvar k = 0; k <= QLEN; k++) begin : g_tbl
    assign tbl[k] = SIN_W'(poly_sine_q16(k, QB));
  end

  always_comb begin
    // round to nearest entry, carry out of bit 15 wraps the turn
    rnd_sum = {1'b0, angle_i} + 17'(1 << (ANGLE_SHIFT - 1));
    idx     = rnd_sum[15:ANGLE_SHIFT];
    quad    = idx[TABLE_BITS-1 -: 2];
    tidx    = quad[0] ? ((QB+1)'(QLEN) - {1'b0, idx[QB-1:0]}) : {1'b0, idx[QB-1:0]};
    sine_o.mag = tbl[tidx];
    sine_o.neg = quad[1];
  end

endmodule

// ===== sv/fpe_mul.sv =====
// fpe_mul: shared unsigned multiplier with registered product
// Depends on fpe_pkg.
module fpe_mul import fpe_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [MUL_B_W-1:0] b_i,
  output logic [PROD_W-1:0]  p_o
);

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// ===== tb/sv/fpe_point_checker.sv =====
`timescale 1ns / 100ps
// fpe_point_checker: snoops the config, item and point channels of the flight
// path extrapolator, predicts every extrapolated point and compares in order.
// Depends on fpe_pkg for the port types and register codes.
module fpe_point_checker import fpe_pkg::*; #(
  parameter int MAX_STEPS = DEF_MAX_STEPS,
  parameter int SINE_BITS = DEF_SINE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  in_item_t              item_i,
  input  logic                  point_valid_i,
  input  out_item_t             point_i,
  input  logic                  drained_i,
  output int                    pending_o,
  output int                    errors_o
);

  localparam int     QTR_BITS    = SINE_BITS - 2;
  localparam int     QTR_LEN     = 1 << QTR_BITS;
  localparam int     TAB_LEN     = 1 << SINE_BITS;
  localparam int     ANGLE_SHIFT = 16 - SINE_BITS;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint STEP_DIV    = 64'sd14745600;  // 225 * 2^16
  localparam longint KNOT_M      = 64'sd1852;
  localparam longint GS_TOP      = 64'sd16383;
  localparam int     MAX_REPORTS = 10;

  localparam logic [14:0] LEVEL_BAND_RST = 15'd260;
  localparam logic [14:0] ACCEL_BAND_RST = 15'd65;
  localparam logic [14:0] CLIMB_ONE_RST  = 15'd2601;
  localparam logic [14:0] CLIMB_TWO_RST  = 15'd5852;
  localparam logic [6:0]  STEPS_RST      = 7'd60;

  logic [14:0]           level_band = LEVEL_BAND_RST;
  logic [14:0]           accel_band = ACCEL_BAND_RST;
  logic [14:0]           climb_one  = CLIMB_ONE_RST;
  logic [14:0]           climb_two  = CLIMB_TWO_RST;
  logic [STEP_CNT_W-1:0] step_cfg   = STEPS_RST;

  longint    quarter_tab [0:QTR_LEN];
  out_item_t path_points_q [$];
  int        fail_cnt;

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b) / ONE_Q30;
  endfunction

  // odd degree-9 series of sin(pi/2 * x) in Q30, rounded to Q16
  function automatic longint quarter_wave_q16(input int k);
    longint x;
    longint x2;
    longint acc;
    longint s;
    x   = longint'(k) * (ONE_Q30 / QTR_LEN);
    x2  = q30_mul(x, x);
    acc = 64'sd172272;
    acc = q30_mul(acc, x2) - 64'sd5026995;
    acc = q30_mul(acc, x2) + 64'sd85569306;
    acc = q30_mul(acc, x2) - 64'sd693598669;
    acc = q30_mul(acc, x2) + 64'sd1686629713;
    s   = q30_mul(acc, x);
    if (s < 0) s = 0;
    s = (s + 8192) / 16384;
    return (s > 65536) ? 64'sd65536 : s;
  endfunction

  initial begin : build_table
    for (int k = 0; k <= QTR_LEN; k++) quarter_tab[k] = quarter_wave_q16(k);
  end

  function automatic longint heading_sine(input logic [15:0] ang);
    int unsigned idx;
    int unsigned ofs;
    idx = ((32'(ang) + (32'd1 << (ANGLE_SHIFT - 1))) >> ANGLE_SHIFT) & (TAB_LEN - 1);
    ofs = idx & (QTR_LEN - 1);
    case (idx >> QTR_BITS)
      0: return quarter_tab[ofs];
      1: return quarter_tab[QTR_LEN - ofs];
      2: return -quarter_tab[ofs];
      default: return -quarter_tab[QTR_LEN - ofs];
    endcase
  endfunction

  function automatic longint div_nearest(input longint num, input longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // vertical speed the aircraft is heading for
  function automatic longint vs_target(input longint v, input longint a);
    longint lb;
    longint ab;
    longint c1;
    longint c2;
    longint sg;
    longint mag;
    lb = level_band;
    ab = accel_band;
    c1 = climb_one;
    c2 = climb_two;
    if (v > -lb && v < lb) return 0;
    sg = (v > 0) ? 1 : -1;
    // accelerating against the motion: leveling off
    if ((sg < 0 && a > ab) || (sg > 0 && a < -ab)) return 0;
    if ((sg < 0 && a < -ab) || (sg > 0 && a > ab)) begin
      mag = mag64(v);
      if (mag < c1) return sg * c1;
      if (mag < c2) return sg * c2;
    end
    return v;
  endfunction

  function automatic void predict_path(input in_item_t it);
    longint      east;
    longint      north;
    longint      alt;
    longint      vs;
    longint      va;
    longint      gs;
    longint      dgs;
    longint      goal;
    longint      step_len;
    longint      n;
    longint      i;
    logic [15:0] trk;
    out_item_t   pt;
    if (!it.start_valid) return;
    n     = (longint'(step_cfg) > MAX_STEPS) ? MAX_STEPS : longint'(step_cfg);
    east  = it.start_east;
    north = it.start_north;
    alt   = it.start_altitude;
    trk   = it.track_angle;
    gs    = it.ground_speed;
    dgs   = it.ground_speed_rate;
    vs    = it.vertical_speed;
    va    = it.vertical_accel;
    goal  = vs_target(vs, va);
    for (i = 0; i < n; i++) begin
      if (mag64(vs - goal) > mag64(vs + va - goal)) vs += va;
      else vs = goal;
      trk = trk + it.track_rate;
      gs  = gs + dgs;
      if (gs < 0) gs = 0;
      if (gs > GS_TOP) gs = GS_TOP;
      alt      += vs;
      step_len  = gs * KNOT_M;
      east     += div_nearest(step_len * heading_sine(trk), STEP_DIV);
      north    += div_nearest(step_len * heading_sine(trk + QUARTER_TURN), STEP_DIV);
      pt.point_east     = clamp32(east);
      pt.point_north    = clamp32(north);
      pt.point_altitude = clamp32(alt);
      pt.step_number    = i[STEP_NUM_W-1:0];
      pt.last_point     = (i + 1 == n);
      path_points_q.push_back(pt);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    out_item_t want;
    if (!rst_ni) begin
      level_band = LEVEL_BAND_RST;
      accel_band = ACCEL_BAND_RST;
      climb_one  = CLIMB_ONE_RST;
      climb_two  = CLIMB_TWO_RST;
      step_cfg   = STEPS_RST;
      path_points_q.delete();
      fail_cnt   = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (point_valid_i) begin
        if (path_points_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("unexpected point: step %0d e=%0d n=%0d alt=%0d last=%0b",
                     point_i.step_number, point_i.point_east, point_i.point_north,
                     point_i.point_altitude, point_i.last_point);
        end else begin
          want = path_points_q.pop_front();
          if (point_i.point_east !== want.point_east ||
              point_i.point_north !== want.point_north ||
              point_i.point_altitude !== want.point_altitude ||
              point_i.step_number !== want.step_number ||
              point_i.last_point !== want.last_point) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
              $display({"point mismatch: want step %0d e=%0d n=%0d alt=%0d last=%0b,",
                        " got step %0d e=%0d n=%0d alt=%0d last=%0b"},
                       want.step_number, want.point_east, want.point_north,
                       want.point_altitude, want.last_point,
                       point_i.step_number, point_i.point_east, point_i.point_north,
                       point_i.point_altitude, point_i.last_point);
          end
        end
      end
      if (start_i && !busy_i) predict_path(item_i);
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_LEVEL_BAND: level_band = cfg_wdata_i;
          CFG_ACCEL_BAND: accel_band = cfg_wdata_i;
          CFG_CLIMB_ONE:  climb_one  = cfg_wdata_i;
          CFG_CLIMB_TWO:  climb_two  = cfg_wdata_i;
          CFG_STEP_COUNT: step_cfg   = cfg_wdata_i[STEP_CNT_W-1:0];
          default: ;
        endcase
      end
      pending_o <= path_points_q.size();
      errors_o  <= fail_cnt + (drained_i ? path_points_q.size() : 0);
    end
  end

endmodule

// ===== tb/sv/tb_flight_path_extrapolator.sv =====
`timescale 1ns / 100ps
// tb_flight_path_extrapolator: drives directed and random aircraft items and
// register settings into the extrapolator. Depends on fpe_pkg, fpe_point_checker.
module tb_flight_path_extrapolator import fpe_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 12;
  localparam int PHASES         = 12;
  localparam int PHASE_BEATS    = 27;
  localparam logic [CFG_ADDR_W-1:0] CFG_NO_REG = 3'd5;  // unmapped index

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  start;
  logic                  busy;
  in_item_t              item;
  logic                  point_valid;
  out_item_t             point;
  logic                  drained;
  int                    pending;
  int                    errors;

  int idle_pct;
  int cur_lb = 260;
  int cur_ab = 65;
  int cur_c1 = 2601;
  int cur_c2 = 5852;

  flight_path_extrapolator dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .item_i        (item),
    .point_valid_o (point_valid),
    .point_o       (point)
  );

  fpe_point_checker point_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata),
    .start_i       (start),
    .busy_i        (busy),
    .item_i        (item),
    .point_valid_i (point_valid),
    .point_i       (point),
    .drained_i     (drained),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || point_valid || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  function automatic in_item_t mk(input int valid, input int east, input int north,
                                  input int alt, input int trk, input int trate,
                                  input int gs, input int gsr, input int vs,
                                  input int va);
    in_item_t it;
    it.start_valid       = valid[0];
    it.start_east        = east;
    it.start_north       = north;
    it.start_altitude    = alt;
    it.track_angle       = 16'(trk);
    it.track_rate        = 16'(trate);
    it.ground_speed      = 14'(gs);
    it.ground_speed_rate = 12'(gsr);
    it.vertical_speed    = 16'(vs);
    it.vertical_accel    = 16'(va);
    return it;
  endfunction

  // a coordinate within reach of either end of the 32-bit range
  function automatic int near_limit(input int reach);
    if ($urandom_range(1)) return int'(32'h7fff_ffff - $urandom_range(reach));
    return int'(32'h8000_0000 + $urandom_range(reach));
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       vmag;
    int       amag;
    it.start_valid    = ($urandom_range(15) != 0);
    it.start_east     = $urandom;
    it.start_north    = $urandom;
    it.start_altitude = $urandom;
    if ($urandom_range(4) == 0) begin
      it.track_angle       = 16'($urandom);
      it.track_rate        = 16'($urandom);
      it.ground_speed      = 14'($urandom);
      it.ground_speed_rate = 12'($urandom);
      it.vertical_speed    = 16'($urandom);
      it.vertical_accel    = 16'($urandom);
      return it;
    end
    if ($urandom_range(3) == 0) it.start_east = near_limit(8000000);
    if ($urandom_range(3) == 0) it.start_north = near_limit(8000000);
    if ($urandom_range(3) == 0) it.start_altitude = near_limit(2100000);
    it.track_angle = 16'($urandom);
    it.track_rate  = 16'(int'($urandom_range(4000)) - 2000);
    case ($urandom_range(2))
      0: it.ground_speed = 14'($urandom_range(100));
      1: it.ground_speed = 14'(16383 - $urandom_range(100));
      default: it.ground_speed = 14'($urandom);
    endcase
    it.ground_speed_rate = 12'(int'($urandom_range(400)) - 200);
    // vertical speed around the band and climb-rate thresholds
    case ($urandom_range(4))
      0: vmag = cur_lb;
      1: vmag = cur_c1;
      2: vmag = cur_c2;
      3: vmag = 0;
      default: vmag = $urandom_range(9000);
    endcase
    vmag = vmag + int'($urandom_range(40)) - 20;
    if (vmag < 0) vmag = 0;
    if (vmag > 32767) vmag = 32767;
    it.vertical_speed = 16'($urandom_range(1) ? -vmag : vmag);
    case ($urandom_range(2))
      0: amag = cur_ab + int'($urandom_range(6)) - 3;
      1: amag = $urandom_range(2 * cur_ab + 20);
      default: amag = $urandom_range(1000);
    endcase
    if (amag < 0) amag = 0;
    if (amag > 32767) amag = 32767;
    it.vertical_accel = 16'($urandom_range(1) ? -amag : amag);
    return it;
  endfunction

  task automatic apply_settings(input int lb, input int ab, input int c1, input int c2,
                                input int sc);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_LEVEL_BAND;
    cfg_wdata <= 15'(lb);
    @(negedge clk);
    cfg_addr  <= CFG_ACCEL_BAND;
    cfg_wdata <= 15'(ab);
    @(negedge clk);
    cfg_addr  <= CFG_CLIMB_ONE;
    cfg_wdata <= 15'(c1);
    @(negedge clk);
    cfg_addr  <= CFG_CLIMB_TWO;
    cfg_wdata <= 15'(c2);
    @(negedge clk);
    // junk above the 7-bit step count must be dropped
    cfg_addr  <= CFG_STEP_COUNT;
    cfg_wdata <= {8'($urandom), 7'(sc)};
    @(negedge clk);
    cfg_addr  <= CFG_NO_REG;
    cfg_wdata <= 15'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_lb = lb;
    cur_ab = ab;
    cur_c1 = c1;
    cur_c2 = c2;
  endtask

  task automatic send_beat(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      item  <= rand_item();
      @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic hold_until_drained(input int settle);
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (settle) @(negedge clk);
  endtask

  initial begin : stimulus
    int lb;
    int ab;
    int c1;
    int c2;
    int sc;
    int sent;
    in_item_t it;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    start     = 1'b0;
    item      = '0;
    drained   = 1'b0;
    idle_pct  = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: target speed cases and limits
    send_beat(mk(1, 0, 0, 256000, 0, 100, 4000, 10, 0, 0));
    send_beat(mk(0, 5, 5, 5, 5, 5, 5, 5, 5, 5));
    send_beat(mk(1, 1000, -1000, 256000, 8192, -50, 3000, 0, 2000, -200));
    send_beat(mk(1, 1000, -1000, 256000, 8192, -50, 3000, 0, -2000, 200));
    send_beat(mk(1, 0, 0, 256000, 4000, 20, 2000, 5, 1000, 200));
    send_beat(mk(1, 0, 0, 256000, 4000, 20, 2000, 5, 4000, 200));
    send_beat(mk(1, 0, 0, 256000, 4000, 20, 2000, 5, 8000, 200));
    send_beat(mk(1, 0, 0, 256000, 60000, -20, 2000, 5, -1000, -200));
    send_beat(mk(1, 0, 0, 256000, 60000, -20, 2000, 5, -4000, -200));
    send_beat(mk(1, 0, 0, 256000, 30000, 0, 2000, 0, 1000, 30));
    send_beat(mk(1, 2147483000, 0, 0, 16384, 0, 16000, 2047, 0, 0));
    send_beat(mk(1, 0, 0, 0, 0, 0, 5, -2048, 0, 0));
    send_beat(mk(1, 0, -2147483000, 0, 32768, 0, 16383, 0, 0, 0));
    send_beat(mk(1, 0, 0, 2147483000, 0, 0, 0, 0, 32767, 32767));
    send_beat(mk(1, 0, 0, -2147483000, 0, 0, 0, 0, -32768, -32768));
    send_beat(mk(1, 32'sh8000_0000, 2147483647, 0, 65535, 32767, 100, 0, 0, 0));
    send_beat(mk(1, 0, 0, 0, 1000, -32768, 8000, -5, 0, 0));
    send_beat(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_beat(mk(1, -1, -1, -1, 65535, -1, 16383, -1, -1, -1));
    hold_until_drained(SETTLE_CYCLES);

    // zero level band: still air counts as descending; step count saturates
    apply_settings(0, 65, 2601, 5852, 100);
    send_beat(mk(1, 0, 0, 0, 0, 0, 1000, 0, 0, -200));
    send_beat(mk(1, 0, 0, 0, 0, 0, 1000, 0, 0, 0));
    hold_until_drained(SETTLE_CYCLES);
    apply_settings(260, 65, 2601, 5852, 0);
    send_beat(mk(1, 0, 0, 0, 0, 0, 1000, 0, 1000, 200));
    hold_until_drained(SETTLE_CYCLES);
    apply_settings(260, 65, 2601, 5852, 1);
    send_beat(mk(1, 0, 0, 0, 0, 0, 1000, 0, 3000, 500));
    send_beat(mk(1, -1, -1, -1, 0, 0, 1000, 0, 5000, -100));
    hold_until_drained(SETTLE_CYCLES);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lb = 0; ab = 0; c1 = 0; c2 = 0; sc = 1; end
        1: begin lb = 32767; ab = 32767; c1 = 32767; c2 = 32767; sc = 64; end
        2: begin lb = 32767; ab = 0; c1 = 32767; c2 = 0; sc = 127; end
        default: begin
          lb = $urandom_range(1000);
          ab = $urandom_range(300);
          c1 = $urandom_range(1000, 4000);
          c2 = $urandom_range(4000, 9000);
          sc = ($urandom_range(5) == 0) ? 64 : $urandom_range(1, 16);
        end
      endcase
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 54;
        default: idle_pct = 20;
      endcase
      apply_settings(lb, ab, c1, c2, sc);
      sent = 0;
      while (sent < PHASE_BEATS) begin
        it = rand_item();
        if ($urandom_range(24) == 0) hold_until_drained(0);
        send_beat(it);
        if (it.start_valid) sent++;
      end
      hold_until_drained(SETTLE_CYCLES);
    end

    drained <= 1'b1;
    repeat (2) @(negedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/fpe_pkg.sv
sv/fpe_sine.sv
sv/fpe_mul.sv
sv/flight_path_extrapolator.sv
tb/sv/fpe_point_checker.sv
tb/sv/tb_flight_path_extrapolator.sv
